// ----- rtl/csp_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csp_pkg: shared types and constants for the counting sort block
// Holds widths, action codes, controller states and the command/status bundles.
// ---------------------------------------------------------------------------
package csp_pkg;

    localparam int MAX_ITEMS = 1024;
    localparam int NUM_KEYS  = 256;
    localparam int KEY_W     = 8;
    localparam int POS_W     = 11;
    localparam int VAL_W     = 11;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int BKT_W     = $clog2(NUM_KEYS);
    localparam int BND_W     = $clog2(NUM_KEYS + 1);

    localparam logic [2:0] ACT_LOAD     = 3'd0;
    localparam logic [2:0] ACT_FINISH   = 3'd1;
    localparam logic [2:0] ACT_RD_PERM  = 3'd2;
    localparam logic [2:0] ACT_RD_BOUND = 3'd3;
    localparam logic [2:0] ACT_CLEAR    = 3'd4;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_PREFIX,
        ST_PFX_END,
        ST_SCAT_RD,
        ST_SCAT_END,
        ST_SCAT_WR,
        ST_READ,
        ST_OUT
    } csp_state_t;

    typedef struct packed {
        logic             clr_step;    // zero one histogram entry
        logic             clr_all;     // clear count and flags
        logic             load;        // store key, fetch its histogram count
        logic             hist_wr;     // write back the bumped count
        logic             pfx_start;
        logic             pfx_step;    // fetch one histogram entry for the prefix sum
        logic             scat_rd;     // fetch key i
        logic             scat_end;    // fetch the bucket end of key i
        logic             scat_wr;     // decrement end, write permutation
        logic             rd_issue;    // launch boundary or permutation read
        logic             rd_perm;
        logic             finish_done;
    } csp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic pfx_last;
        logic scat_empty;
        logic scat_last;
    } csp_stat_t;

endpackage

// ----- rtl/csp_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csp_ctrl: sequencing controller
// Steps the clear sweep, the load write-back, the finish pass and the registered reads.
// ---------------------------------------------------------------------------
module csp_ctrl
    import csp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] action,
    input  logic       out_valid,
    input  logic       out_stall,
    output logic       res_load,
    output csp_cmd_t   cmd,
    input  csp_stat_t  stat
);

    csp_state_t state_reg, state_next;
    logic       out_free;

    assign out_free = !out_valid || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        logic acc;
        state_next = state_reg;
        cmd        = '0;
        res_load   = 1'b0;
        in_stall   = 1'b1;
        acc        = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                acc      = in_valid;
                if (acc)
                begin
                    unique case (action)
                        ACT_LOAD:
                        begin
                            cmd.load   = 1'b1;
                            state_next = ST_LOAD;
                        end
                        ACT_FINISH:
                        begin
                            cmd.pfx_start = 1'b1;
                            state_next    = ST_PREFIX;
                        end
                        ACT_RD_PERM, ACT_RD_BOUND:
                        begin
                            cmd.rd_issue = 1'b1;
                            cmd.rd_perm  = (action == ACT_RD_PERM);
                            state_next   = ST_READ;
                        end
                        ACT_CLEAR:
                        begin
                            cmd.clr_all = 1'b1;
                            state_next  = ST_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOAD:
            begin
                cmd.hist_wr = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_PREFIX:
            begin
                cmd.pfx_step = 1'b1;
                if (stat.pfx_last)
                    state_next = ST_PFX_END;
            end
            ST_PFX_END:
            begin
                state_next = stat.scat_empty ? ST_OUT : ST_SCAT_RD;
            end
            ST_SCAT_RD:
            begin
                cmd.scat_rd = 1'b1;
                state_next  = ST_SCAT_END;
            end
            ST_SCAT_END:
            begin
                cmd.scat_end = 1'b1;
                state_next   = ST_SCAT_WR;
            end
            ST_SCAT_WR:
            begin
                cmd.scat_wr = 1'b1;
                state_next  = stat.scat_last ? ST_OUT : ST_SCAT_RD;
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    res_load        = 1'b1;
                    cmd.finish_done = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- rtl/csp_datapath.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csp_datapath: stores, histogram, prefix sums and scatter
// Key store, histogram, boundary and permutation memories with their ports.
// ---------------------------------------------------------------------------
module csp_datapath
    import csp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  csp_cmd_t           cmd,
    output csp_stat_t          stat,
    input  logic [KEY_W-1:0]   key,
    input  logic [POS_W-1:0]   position,
    input  logic               res_load,
    output logic [VAL_W-1:0]   value,
    output logic               error
);

    logic [KEY_W-1:0] key_mem   [MAX_ITEMS];
    logic [CNT_W-1:0] cnt_mem   [NUM_KEYS];
    logic [CNT_W-1:0] end_mem   [NUM_KEYS];
    logic [CNT_W-1:0] bound_mem [NUM_KEYS];
    logic [IDX_W-1:0] perm_mem  [MAX_ITEMS];

    logic [CNT_W-1:0] count_reg;
    logic             sorted_reg, overflow_reg;
    logic [BKT_W-1:0] walk_reg;
    logic [CNT_W-1:0] sum_reg;
    logic [CNT_W-1:0] item_reg;
    logic [KEY_W-1:0] skey_reg;
    logic [CNT_W-1:0] send_reg;
    logic [CNT_W-1:0] rd_data_reg;
    logic             rd_zero_reg, rd_err_reg, fin_reg;
    logic [VAL_W-1:0] value_reg;
    logic             error_reg;
    logic [CNT_W-1:0] cnt_q_reg;
    logic [BKT_W-1:0] bkt_reg;
    logic             ld_ok_reg;
    logic             pfx_v_reg;
    logic [BKT_W-1:0] acc_idx_reg;
    logic [BKT_W-1:0] bkt;
    logic             load_ok;
    logic [CNT_W-1:0] sum_next;
    logic [CNT_W-1:0] dec;

    assign bkt      = key[BKT_W-1:0];
    assign load_ok  = cmd.load && (count_reg < CNT_W'(MAX_ITEMS));
    assign sum_next = sum_reg + cnt_q_reg;
    assign dec      = send_reg - 1'b1;

    assign stat.clr_last   = (walk_reg == BKT_W'(NUM_KEYS - 1));
    assign stat.pfx_last   = (walk_reg == BKT_W'(NUM_KEYS - 1));
    assign stat.scat_empty = (count_reg == '0);
    assign stat.scat_last  = (item_reg + 1'b1 == count_reg);

    // histogram: registered read, write-back in the next cycle
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            cnt_mem[walk_reg] <= '0;
        else if (cmd.hist_wr && ld_ok_reg)
            cnt_mem[bkt_reg] <= cnt_q_reg + 1'b1;
        if (cmd.load || cmd.pfx_step)
            cnt_q_reg <= cnt_mem[cmd.load ? bkt : walk_reg];
        if (cmd.load)
        begin
            bkt_reg   <= bkt;
            ld_ok_reg <= load_ok;
        end
        acc_idx_reg <= walk_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load_ok)
            key_mem[count_reg[IDX_W-1:0]] <= key;
        if (cmd.scat_rd)
            skey_reg <= key_mem[item_reg[IDX_W-1:0]];
    end

    // bound_mem holds boundary k+1; boundary 0 is zero
    always_ff @(posedge clk)
    begin
        if (pfx_v_reg)
        begin
            bound_mem[acc_idx_reg] <= sum_next;
            end_mem[acc_idx_reg]   <= sum_next;
        end
        else if (cmd.scat_wr && send_reg != '0)
            end_mem[skey_reg[BKT_W-1:0]] <= dec;
        if (cmd.scat_end)
            send_reg <= end_mem[skey_reg[BKT_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scat_wr && send_reg != '0)
            perm_mem[dec[IDX_W-1:0]] <= item_reg[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
        begin
            if (cmd.rd_perm)
            begin
                rd_data_reg <= CNT_W'(perm_mem[position[IDX_W-1:0]]);
                rd_zero_reg <= 1'b0;
                rd_err_reg  <= !sorted_reg || position >= POS_W'(count_reg);
            end
            else
            begin
                rd_data_reg <= bound_mem[BKT_W'(position - 1'b1)];
                rd_zero_reg <= (position == '0);
                rd_err_reg  <= !sorted_reg || position > POS_W'(NUM_KEYS);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            sorted_reg   <= 1'b0;
            overflow_reg <= 1'b0;
            walk_reg     <= '0;
            sum_reg      <= '0;
            item_reg     <= '0;
            fin_reg      <= 1'b0;
            pfx_v_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clr_all)
            begin
                count_reg    <= '0;
                sorted_reg   <= 1'b0;
                overflow_reg <= 1'b0;
            end
            if (cmd.load)
            begin
                sorted_reg <= 1'b0;
                if (count_reg < CNT_W'(MAX_ITEMS))
                    count_reg <= count_reg + 1'b1;
                else
                    overflow_reg <= 1'b1;
            end
            if (cmd.clr_step || cmd.pfx_step)
                walk_reg <= walk_reg + 1'b1;
            pfx_v_reg <= cmd.pfx_step;
            if (cmd.pfx_start)
            begin
                sum_reg  <= '0;
                item_reg <= '0;
            end
            if (pfx_v_reg)
                sum_reg <= sum_next;
            if (cmd.scat_wr)
                item_reg <= item_reg + 1'b1;
            fin_reg <= cmd.pfx_start ? 1'b1 : (cmd.rd_issue ? 1'b0 : fin_reg);
            if (cmd.finish_done)
                sorted_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            if (fin_reg)
            begin
                value_reg <= VAL_W'(count_reg);
                error_reg <= overflow_reg;
            end
            else
            begin
                value_reg <= (rd_err_reg || rd_zero_reg) ? '0 : VAL_W'(rd_data_reg);
                error_reg <= rd_err_reg;
            end
        end
    end

    assign value = value_reg;
    assign error = error_reg;

endmodule

// ----- rtl/counting_sort_permutation.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// counting_sort_permutation: counting sort over 8-bit keys
// Top level joining the controller and the datapath, plus the output valid.
// ---------------------------------------------------------------------------
// Usage: every input transaction carries action, key and position on
// in_valid/in_stall. A load stores its key and fetches the histogram count
// in the accepting cycle, writes the bumped count back in the next one with
// input stalled, and returns no result. Clear drops all items and then
// sweeps the histogram, one bucket a cycle, with input stalled; the same
// sweep runs after reset. Finish reads the histogram once, with a tail
// state for the last sum, to build the bucket boundaries, then scatters
// each stored item (read key, read bucket end, write permutation) and
// returns the item count with the overflow flag. A boundary or permutation
// read goes through the registered memory port. Results leave on
// out_valid/out_stall as value and error; while the receiver stalls the
// result holds, and a further read or finish result waits with input stalled.
// ---------------------------------------------------------------------------
module counting_sort_permutation
    import csp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         action,
    input  logic [KEY_W-1:0]   key,
    input  logic [POS_W-1:0]   position,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [VAL_W-1:0]   value,
    output logic               error
);

    csp_cmd_t  cmd;
    csp_stat_t stat;
    logic      res_load;
    logic      out_valid_reg;

    csp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .out_valid (out_valid_reg),
        .out_stall (out_stall),
        .res_load  (res_load),
        .cmd       (cmd),
        .stat      (stat)
    );

    csp_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .key      (key),
        .position (position),
        .res_load (res_load),
        .value    (value),
        .error    (error)
    );

    // hold the result until the transaction completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- bench/sort_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sort_checker: result predictor and comparator for the counting sort block
// Watches both channels, mirrors the sort state and checks every result.
// ---------------------------------------------------------------------------
module sort_checker
    import csp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_stall,
    input  logic [2:0]       action,
    input  logic [KEY_W-1:0] key,
    input  logic [POS_W-1:0] position,
    input  logic             out_valid,
    input  logic             out_stall,
    input  logic [VAL_W-1:0] value,
    input  logic             error,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             error;
    } sort_result_t;

    sort_result_t        results_due[$];
    logic [KEY_W-1:0]    key_store [MAX_ITEMS];
    int                  histogram [NUM_KEYS];
    int                  bounds    [NUM_KEYS+1];
    int                  perm      [MAX_ITEMS];
    int                  n_items;
    bit                  sorted;
    bit                  overflowed;

    assign pending = results_due.size();

    // Rebuild boundaries, then scatter items into descending bucket ends.
    task automatic build_sort();
        int ends [NUM_KEYS];
        int sum;
        sum = 0;
        bounds[0] = 0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            sum += histogram[k];
            bounds[k+1] = sum;
            ends[k] = sum;
        end
        for (int i = 0; i < n_items; i++)
        begin
            ends[key_store[i]]--;
            perm[ends[key_store[i]]] = i;
        end
        sorted = 1;
    endtask

    task automatic predict(input logic [2:0] act, input logic [KEY_W-1:0] k,
                           input logic [POS_W-1:0] pos);
        sort_result_t r;
        r = '0;
        case (act)
            ACT_LOAD:
            begin
                if (n_items >= MAX_ITEMS)
                    overflowed = 1;
                else
                begin
                    key_store[n_items] = k;
                    histogram[k]++;
                    n_items++;
                end
                sorted = 0;
                return;
            end
            ACT_FINISH:
            begin
                build_sort();
                r.value = VAL_W'(n_items);
                r.error = overflowed;
            end
            ACT_RD_PERM:
                if (!sorted || pos >= n_items) r.error = 1;
                else r.value = VAL_W'(perm[pos]);
            ACT_RD_BOUND:
                if (!sorted || pos > NUM_KEYS) r.error = 1;
                else r.value = VAL_W'(bounds[pos]);
            ACT_CLEAR:
            begin
                foreach (histogram[k2]) histogram[k2] = 0;
                n_items = 0;
                sorted = 0;
                overflowed = 0;
                return;
            end
            default: return;
        endcase
        results_due.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count <= 0;
            results_due.delete();
            foreach (histogram[k]) histogram[k] = 0;
            n_items = 0;
            sorted = 0;
            overflowed = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result value=%0d error=%0b", value, error);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    sort_result_t e;
                    e = results_due.pop_front();
                    if (e.value !== value || e.error !== error)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected value=%0d error=%0b, got %0d %0b",
                                     e.value, e.error, value, error);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict(action, key, position);
        end
    end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: testbench for counting_sort_permutation
// Drives directed and random load/finish/read/clear sets with random bursts
// and stalls; the checker predicts and compares each result.
// ---------------------------------------------------------------------------
module tb_top;
    import csp_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    // action codes with no function
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [2:0]       action;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] position;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [VAL_W-1:0] value;
    logic             error;
    int               fail_count;
    int               pending;
    int               idle_cycles = 0;
    int               burst_left;
    int               stall_mode = 0;

    counting_sort_permutation u_dut (.*);

    sort_checker u_checker (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Receiver stall: switch between no stall, light and heavy stalling.
    always @(negedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: out_stall <= 0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Watchdog: count cycles with no transaction on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Send one transaction; hold the payload until it is accepted, and
    // insert random gaps between bursts. Stall is sampled before each edge.
    task automatic send(input logic [2:0] act, input logic [KEY_W-1:0] k,
                        input logic [POS_W-1:0] pos);
        logic stalled;
        if (burst_left == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1;
        action   <= act;
        key      <= k;
        position <= pos;
        do
        begin
            stalled = in_stall;
            @(posedge clk);
        end
        while (stalled);
        @(negedge clk);
    endtask

    // Load n keys (narrow key range to force duplicates), finish, read back, send unused codes.
    task automatic sort_set(input int n, input int key_span);
        int pick;
        for (int i = 0; i < n; i++)
            send(ACT_LOAD, KEY_W'($urandom_range(0, key_span)), POS_W'($urandom));
        send(ACT_FINISH, KEY_W'($urandom), POS_W'($urandom));
        repeat ($urandom_range(4, 14))
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                send(ACT_RD_PERM, KEY_W'($urandom),
                     POS_W'((pick == 0) ? $urandom_range(0, 2047) : $urandom_range(0, n)));
            else if (pick < 9)
                send(ACT_RD_BOUND, KEY_W'($urandom),
                     POS_W'((pick == 5) ? $urandom_range(0, 2047) : $urandom_range(0, 257)));
            else
                send(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)), KEY_W'($urandom),
                     POS_W'($urandom));
        end
    endtask

    int sent;

    initial
    begin
        rst_n = 0; in_valid = 0; action = ACT_LOAD; key = 0; position = 0;
        burst_left = 0;
        repeat (4) @(negedge clk);
        rst_n = 1;

        // Directed: reads before finish, empty finish, extremes, unused codes.
        send(ACT_RD_PERM, '0, '0);
        send(ACT_RD_BOUND, '0, POS_W'(NUM_KEYS));
        send(ACT_FINISH, '0, '0);
        send(ACT_RD_BOUND, '0, POS_W'(NUM_KEYS));
        send(ACT_RD_PERM, '0, '0);
        send(ACT_LOAD, 8'hFF, 11'h7FF);
        send(ACT_LOAD, 8'h00, '0);
        send(ACT_LOAD, 8'hFF, '0);
        send(ACT_LOAD, 8'hAA, '0);
        send(ACT_LOAD, 8'h55, '0);
        send(ACT_RD_BOUND, '0, 11'd1);
        send(ACT_FINISH, '0, '0);
        send(ACT_FINISH, '0, '0);
        send(ACT_RD_PERM, '0, '0);
        send(ACT_RD_PERM, '0, 11'd4);
        send(ACT_RD_PERM, '0, 11'd5);
        send(ACT_RD_BOUND, '0, 11'd256);
        send(ACT_RD_BOUND, '0, 11'd257);
        send(ACT_RD_BOUND, '0, 11'h7FF);
        send(ACT_SPARE_LO, '0, '0);
        send(ACT_SPARE_HI, 8'hFF, 11'h7FF);
        send(ACT_LOAD, 8'h10, '0);
        send(ACT_RD_BOUND, '0, '0);
        send(ACT_CLEAR, '0, '0);
        send(ACT_RD_PERM, '0, '0);

        // Random sets, mostly small.
        sent = 0;
        while (sent < 400)
        begin
            int n;
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
            sort_set(n, ($urandom_range(0, 1)) ? 255 : 3);
            sent += n + 10;
            if ($urandom_range(0, 2) == 0) send(ACT_CLEAR, KEY_W'($urandom), POS_W'($urandom));
        end

        // Larger set with many duplicates, then finish on an empty store.
        send(ACT_CLEAR, '0, '0);
        for (int i = 0; i < 100; i++)
            send(ACT_LOAD, KEY_W'($urandom_range(0, 15)), '0);
        send(ACT_FINISH, '0, '0);
        send(ACT_RD_PERM, '0, 11'd99);
        send(ACT_RD_PERM, '0, 11'd100);
        send(ACT_RD_BOUND, '0, POS_W'(NUM_KEYS));
        send(ACT_CLEAR, '0, '0);
        send(ACT_FINISH, '0, '0);
        in_valid <= 0;

        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- counting_sort_permutation.f -----
rtl/csp_pkg.sv
rtl/csp_ctrl.sv
rtl/csp_datapath.sv
rtl/counting_sort_permutation.sv
bench/sort_checker.sv
bench/tb_top.sv
